// ===== rtl/core/jdc_pkg.sv =====
// Shared widths, constants and stage payload type for the day number to date converter.
package jdc_pkg;

  localparam int JD_W        = 23;
  localparam int X_W         = 24;
  localparam int QE_W        = 15;
  localparam int YEAR_W      = 16;
  localparam int CENT_W      = 8;
  localparam int DOY_W       = 10;
  localparam int MON_W       = 6;
  localparam int PROD_W      = 32;

  localparam int YEAR_STAGES = 4;
  localparam int DATE_STAGES = 5;
  localparam int NUM_STAGES  = YEAR_STAGES + DATE_STAGES;

  localparam logic [JD_W-1:0] GREG_START_RESET = 23'd2361222;

  localparam logic [X_W-1:0] GREG_BIAS  = 24'd32044;
  localparam logic [X_W-1:0] JUL_BIAS   = 24'd32082;
  localparam logic [X_W-1:0] GREG_RECIP = 24'd11759221;
  localparam logic [X_W-1:0] JUL_RECIP  = 24'd11758979;
  localparam int             RECIP_SHIFT = 32;

  localparam logic [PROD_W-1:0] GREG_SCALE  = 32'd400;
  localparam logic [PROD_W-1:0] JUL_SCALE   = 32'd4;
  localparam logic [PROD_W-1:0] GREG_PERIOD = 32'd146097;
  localparam logic [PROD_W-1:0] JUL_PERIOD  = 32'd1461;

  localparam logic [YEAR_W-1:0] YEAR_BIAS = 16'd4800;

  localparam int             QUAD_W       = 27;
  localparam int             EPOCH_W      = 28;
  localparam logic [QUAD_W-1:0]  YEAR_DAYS4  = 27'd1461;
  localparam logic [EPOCH_W-1:0] EPOCH_DAY   = 28'd1720995;
  localparam logic [27:0]        CENT_RECIP  = 28'd5243;
  localparam int                 CENT_SHIFT  = 19;

  localparam logic [21:0] MON_RECIP  = 22'd2141;
  localparam int          MON_SHIFT  = 16;
  localparam logic [23:0] MON_SCALE  = 24'd10000;
  localparam logic [23:0] MON_PERIOD = 24'd306001;
  localparam logic [15:0] FIFTH_RECIP = 16'd205;
  localparam int          FIFTH_SHIFT = 10;

  localparam logic signed [YEAR_W-1:0] YEAR_MAX = 16'sd9999;

  typedef struct packed {
    logic [JD_W-1:0]          jd;
    logic                     greg;
    logic signed [YEAR_W-1:0] year;
  } jdc_year_t;

endpackage

// ===== rtl/core/jdc_year_pipe.sv =====
// Year estimate stages: calendar select, reciprocal multiply and one-step correction.
module jdc_year_pipe import jdc_pkg::*; (
  input  logic                   clk,
  input  logic [YEAR_STAGES-1:0] load,
  input  logic [JD_W-1:0]        julian_day,
  input  logic [JD_W-1:0]        greg_start,
  output jdc_year_t              year_out
);

  logic [JD_W-1:0]   jd0_r, jd1_r, jd2_r, jd3_r;
  logic              greg0_r, greg1_r, greg2_r, greg3_r;
  logic [X_W-1:0]    x0_r, x1_r;
  logic [QE_W-1:0]   qe1_r, qe2_r;
  logic [PROD_W-1:0] xp2_r, qd2_r;
  logic signed [YEAR_W-1:0] year3_r;

  logic              greg0;
  logic [X_W-1:0]    x0_nxt;
  logic [X_W-1:0]    recip1;
  logic [2*X_W-1:0]  prod1;
  logic [PROD_W-1:0] xp2_nxt, qd2_nxt;
  logic [PROD_W-1:0] rem3;
  logic              inc3;
  logic [YEAR_W-1:0] year3_nxt;

  assign greg0  = julian_day >= greg_start;
  assign x0_nxt = {1'b0, julian_day} + (greg0 ? GREG_BIAS : JUL_BIAS);

  assign recip1 = greg0_r ? GREG_RECIP : JUL_RECIP;
  assign prod1  = {{X_W{1'b0}}, x0_r} * {{X_W{1'b0}}, recip1};

  assign xp2_nxt = {{(PROD_W-X_W){1'b0}}, x1_r} * (greg1_r ? GREG_SCALE : JUL_SCALE);
  assign qd2_nxt = {{(PROD_W-QE_W){1'b0}}, qe1_r} * (greg1_r ? GREG_PERIOD : JUL_PERIOD);

  assign rem3      = xp2_r - qd2_r;
  assign inc3      = rem3 >= (greg2_r ? GREG_PERIOD : JUL_PERIOD);
  assign year3_nxt = {1'b0, qe2_r} + {{(YEAR_W-1){1'b0}}, inc3} - YEAR_BIAS;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      jd0_r   <= julian_day;
      greg0_r <= greg0;
      x0_r    <= x0_nxt;
    end
    if (load[1]) begin
      jd1_r   <= jd0_r;
      greg1_r <= greg0_r;
      x1_r    <= x0_r;
      qe1_r   <= prod1[RECIP_SHIFT +: QE_W];
    end
    if (load[2]) begin
      jd2_r   <= jd1_r;
      greg2_r <= greg1_r;
      qe2_r   <= qe1_r;
      xp2_r   <= xp2_nxt;
      qd2_r   <= qd2_nxt;
    end
    if (load[3]) begin
      jd3_r   <= jd2_r;
      greg3_r <= greg2_r;
      year3_r <= $signed(year3_nxt);
    end
  end

  assign year_out.jd   = jd3_r;
  assign year_out.greg = greg3_r;
  assign year_out.year = year3_r;

endmodule

// ===== rtl/core/jdc_date_pipe.sv =====
// Date stages: year start day, day of year, month split and final date fixup.
module jdc_date_pipe import jdc_pkg::*; (
  input  logic                   clk,
  input  logic [DATE_STAGES-1:0] load,
  input  jdc_year_t              year_in,
  output logic [4:0]             day_of_month,
  output logic [3:0]             month_of_year,
  output logic signed [14:0]     year_signed,
  output logic                   range_error
);

  logic [JD_W-1:0]          jd4_r;
  logic                     greg4_r;
  logic signed [YEAR_W-1:0] year4_r, year5_r, year6_r, year7_r;
  logic signed [QUAD_W-1:0] quad4_r;
  logic [CENT_W-1:0]        cent4_r;
  logic [DOY_W-1:0]         doy5_r, doy6_r, doy7_r;
  logic [MON_W-1:0]         me6_r, mon7_r;
  logic [4:0]               day8_r;
  logic [3:0]               month8_r;
  logic signed [14:0]       year8_r;
  logic                     err8_r;

  logic signed [QUAD_W-1:0]  quad4_nxt;
  logic [QE_W-1:0]           mag4;
  logic [27:0]               cprod4;
  logic [CENT_W-1:0]         cq5;
  logic signed [9:0]         corr5;
  logic signed [EPOCH_W-1:0] start5;
  logic signed [EPOCH_W-1:0] diff5;
  logic [21:0]               mprod6;
  logic [23:0]               rem7;
  logic [MON_W-1:0]          mon7_nxt;

  logic [7:0]               tri8;
  logic [15:0]              fprod8;
  logic [DOY_W-1:0]         dfull8;
  logic [MON_W-1:0]         mon8;
  logic signed [YEAR_W-1:0] yr8;
  logic                     err8;

  assign quad4_nxt = QUAD_W'(year_in.year) * $signed(YEAR_DAYS4);
  assign mag4      = year_in.year[YEAR_W-1] ? QE_W'(-year_in.year) : QE_W'(year_in.year);
  assign cprod4    = {{(28-QE_W){1'b0}}, mag4} * CENT_RECIP;

  assign cq5   = cent4_r >> 2;
  always_comb begin
    if (!greg4_r) begin
      corr5 = '0;
    end else if (year4_r[YEAR_W-1]) begin
      corr5 = $signed(10'd2 + {2'b0, cent4_r} - {2'b0, cq5});
    end else begin
      corr5 = $signed(10'd2 + {2'b0, cq5} - {2'b0, cent4_r});
    end
  end
  assign start5 = $signed(EPOCH_DAY) + EPOCH_W'(quad4_r >>> 2) + EPOCH_W'(corr5);
  assign diff5  = $signed({{(EPOCH_W-JD_W){1'b0}}, jd4_r}) - start5;

  assign mprod6 = {{(22-DOY_W){1'b0}}, doy5_r} * MON_RECIP;

  assign rem7     = {{(24-DOY_W){1'b0}}, doy6_r} * MON_SCALE
                  - {{(24-MON_W){1'b0}}, me6_r} * MON_PERIOD;
  assign mon7_nxt = me6_r + {{(MON_W-1){1'b0}}, (rem7 >= MON_PERIOD)};

  always_comb begin
    tri8   = {2'b0, mon7_r} * 8'd3;
    fprod8 = {8'b0, tri8} * FIFTH_RECIP;
    dfull8 = doy7_r - {{(DOY_W-MON_W){1'b0}}, mon7_r} * 10'd30
           - {{(DOY_W-MON_W){1'b0}}, fprod8[FIFTH_SHIFT +: MON_W]};
    mon8   = mon7_r - 6'd1;
    if (mon8 > 6'd12) begin
      mon8 = mon8 - 6'd12;
    end
    yr8 = year7_r;
    if (mon8 <= 6'd2) begin
      yr8 = yr8 + 16'sd1;
    end
    if (yr8 <= 16'sd0) begin
      yr8 = yr8 - 16'sd1;
    end
    err8 = yr8 > YEAR_MAX;
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      jd4_r   <= year_in.jd;
      greg4_r <= year_in.greg;
      year4_r <= year_in.year;
      quad4_r <= quad4_nxt;
      cent4_r <= cprod4[CENT_SHIFT +: CENT_W];
    end
    if (load[1]) begin
      year5_r <= year4_r;
      doy5_r  <= diff5[DOY_W-1:0];
    end
    if (load[2]) begin
      year6_r <= year5_r;
      doy6_r  <= doy5_r;
      me6_r   <= mprod6[MON_SHIFT +: MON_W];
    end
    if (load[3]) begin
      year7_r <= year6_r;
      doy7_r  <= doy6_r;
      mon7_r  <= mon7_nxt;
    end
    if (load[4]) begin
      err8_r   <= err8;
      day8_r   <= err8 ? 5'd0 : dfull8[4:0];
      month8_r <= err8 ? 4'd0 : mon8[3:0];
      year8_r  <= err8 ? 15'sd0 : $signed(yr8[14:0]);
    end
  end

  assign day_of_month  = day8_r;
  assign month_of_year = month8_r;
  assign year_signed   = year8_r;
  assign range_error   = err8_r;

endmodule

// ===== rtl/core/julian_day_to_calendar_date.sv =====
// Top level: Julian day number to calendar date converter with stage flow control.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_julian_day
//   out_     output     out_valid / out_ready  out_day_of_month, out_month_of_year,
//                                              out_year_signed, out_range_error
//   cfg_     input      cfg_valid / cfg_ready  cfg_gregorian_start_day
//
// One transaction per cycle unless all stages are full and stalled; each result passes the
// nine register stages (year reciprocal multiply and correction, year start day, month
// split). Synchronous active-low reset clears the stage valid bits and loads the switch
// day register. A stalled output holds its stage; upstream stages keep filling empty
// slots, so in_ready drops only when every stage holds a transaction.
module julian_day_to_calendar_date import jdc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [JD_W-1:0]    in_julian_day,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_day_of_month,
  output logic [3:0]         out_month_of_year,
  output logic signed [14:0] out_year_signed,
  output logic               out_range_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [JD_W-1:0]    cfg_gregorian_start_day
);

  logic [NUM_STAGES-1:0] valid_r, valid_nxt;
  logic [NUM_STAGES-1:0] rdy, feed, load;
  logic [JD_W-1:0]       greg_start_r;
  jdc_year_t             year_mid;

  assign feed = {valid_r[NUM_STAGES-2:0], in_valid};

  always_comb begin
    rdy[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign load      = rdy & feed;
  assign valid_nxt = (rdy & feed) | (~rdy & valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      greg_start_r <= GREG_START_RESET;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_valid && cfg_ready) begin
        greg_start_r <= cfg_gregorian_start_day;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid_r[NUM_STAGES-1];
  assign cfg_ready = 1'b1;

  jdc_year_pipe u_year (
    .clk        (clk),
    .load       (load[YEAR_STAGES-1:0]),
    .julian_day (in_julian_day),
    .greg_start (greg_start_r),
    .year_out   (year_mid)
  );

  jdc_date_pipe u_date (
    .clk           (clk),
    .load          (load[NUM_STAGES-1:YEAR_STAGES]),
    .year_in       (year_mid),
    .day_of_month  (out_day_of_month),
    .month_of_year (out_month_of_year),
    .year_signed   (out_year_signed),
    .range_error   (out_range_error)
  );

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (&valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while every stage is held");

  a_month_day_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_error) |->
      (out_month_of_year >= 4'd1 && out_month_of_year <= 4'd12 && out_day_of_month != 5'd0))
    else $error("month or day out of range on a valid date");

  a_no_year_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_error) |-> out_year_signed != 15'sd0)
    else $error("year zero produced");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the Julian day number to calendar date converter.
`timescale 1ns / 1ps

module tb;
  import jdc_pkg::*;

  localparam int     CYCLE_LIMIT   = 400000;
  localparam longint GREG_Y_ORIGIN = 1721120;
  localparam longint JUL_Y_ORIGIN  = 1721118;
  localparam longint YEAR0_DAY     = 1720995;
  localparam longint LAST_GREG_DAY = 5373484;
  localparam longint FIRST_AD_DAY  = 1721424;
  localparam longint LAST_YEAR     = 9999;
  localparam int     DAY_MAX       = 8388607;

  typedef struct packed {
    logic [4:0]         day;
    logic [3:0]         month;
    logic signed [14:0] year;
    logic               err;
  } cal_date_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [JD_W-1:0]    in_julian_day = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [4:0]         out_day_of_month;
  logic [3:0]         out_month_of_year;
  logic signed [14:0] out_year_signed;
  logic               out_range_error;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [JD_W-1:0]    cfg_gregorian_start_day = '0;

  cal_date_t       pending_dates[$];
  logic [JD_W-1:0] switch_day = GREG_START_RESET;
  int              mismatch_count = 0;
  int              cycle_count = 0;
  int              src_idle_pct = 30;
  int              sink_idle_pct = 30;
  int              hold_request = 0;
  int              hold_left = 0;

  julian_day_to_calendar_date u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_julian_day           (in_julian_day),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_day_of_month        (out_day_of_month),
    .out_month_of_year       (out_month_of_year),
    .out_year_signed         (out_year_signed),
    .out_range_error         (out_range_error),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_gregorian_start_day (cfg_gregorian_start_day)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic cal_date_t jd_to_date(logic [JD_W-1:0] day, logic [JD_W-1:0] start);
    longint    jd, y, first, doy, m, d;
    bit        greg;
    cal_date_t r;
    jd   = longint'(day);
    greg = day >= start;
    if (greg) y = floor_quot((jd - GREG_Y_ORIGIN) * 10000, 3652425);
    else y = floor_quot((jd - JUL_Y_ORIGIN) * 4, 1461);
    first = YEAR0_DAY + floor_quot(1461 * y, 4);
    if (greg) first += 2 + y / 400 - y / 100;
    doy = jd - first;
    m = floor_quot(doy * 10000, 306001);
    d = doy - floor_quot(306001 * m, 10000);
    m--;
    if (m > 12) m -= 12;
    if (m <= 2) y++;
    if (y <= 0) y--;
    if (y > LAST_YEAR) begin
      r = '{day: '0, month: '0, year: '0, err: 1'b1};
    end else begin
      r.day   = d[4:0];
      r.month = m[3:0];
      r.year  = y[14:0];
      r.err   = 1'b0;
    end
    return r;
  endfunction

  // hold the result channel for a requested stretch, else stall at random
  always @(posedge clk) begin
    if (hold_left == 0 && hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    cal_date_t exp_date;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected result transaction");
        mismatch_count++;
      end else begin
        exp_date = pending_dates.pop_front();
        if (out_day_of_month !== exp_date.day) begin
          $error("day_of_month: expected %0d, actual %0d", exp_date.day, out_day_of_month);
          mismatch_count++;
        end
        if (out_month_of_year !== exp_date.month) begin
          $error("month_of_year: expected %0d, actual %0d", exp_date.month,
                 out_month_of_year);
          mismatch_count++;
        end
        if (out_year_signed !== exp_date.year) begin
          $error("year_signed: expected %0d, actual %0d", exp_date.year, out_year_signed);
          mismatch_count++;
        end
        if (out_range_error !== exp_date.err) begin
          $error("range_error: expected %0d, actual %0d", exp_date.err, out_range_error);
          mismatch_count++;
        end
      end
    end
  end

  task automatic offer_day(input int day);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_julian_day <= day[JD_W-1:0];
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back(jd_to_date(day[JD_W-1:0], switch_day));
  endtask

  task automatic drain_dates();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic write_switch_day(input int value);
    drain_dates();
    cfg_valid               <= 1'b1;
    cfg_gregorian_start_day <= value[JD_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    switch_day = value[JD_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_day();
    int sel, base, day;
    sel = $urandom_range(99);
    if (sel < 35) return $urandom_range(DAY_MAX);
    if (sel < 75) return $urandom_range(int'(LAST_GREG_DAY) + 100);
    case ($urandom_range(3))
      0: base = int'(switch_day);
      1: base = int'(LAST_GREG_DAY);
      2: base = int'(FIRST_AD_DAY);
      default: base = 1721058 + 365 * $urandom_range(100);
    endcase
    day = base + $urandom_range(800) - 400;
    if (day < 0) day = 0;
    if (day > DAY_MAX) day = DAY_MAX;
    return day;
  endfunction

  task automatic test_reset_switch();
    offer_day(int'(GREG_START_RESET) - 1);
    offer_day(int'(GREG_START_RESET));
    offer_day(0);
    offer_day(int'(FIRST_AD_DAY));
    offer_day(int'(FIRST_AD_DAY) - 1);
    offer_day(2451545);
    offer_day(2451604);
    offer_day(int'(LAST_GREG_DAY));
    offer_day(int'(LAST_GREG_DAY) + 1);
    offer_day(DAY_MAX);
  endtask

  task automatic test_switch_extremes();
    write_switch_day(0);
    offer_day(0);
    offer_day(1);
    offer_day(int'(FIRST_AD_DAY) + 1);
    write_switch_day(int'(LAST_GREG_DAY));
    offer_day(int'(LAST_GREG_DAY) - 1);
    offer_day(int'(LAST_GREG_DAY));
    offer_day(5373556);
    offer_day(5373558);
    write_switch_day(DAY_MAX);
    offer_day(DAY_MAX);
    offer_day(5373600);
    offer_day(2361230);
    write_switch_day(2299161);
    offer_day(2299160);
    offer_day(2299161);
  endtask

  task automatic test_random_traffic();
    int starts[7];
    starts = '{2361222, 0, int'(LAST_GREG_DAY), DAY_MAX, 2299161,
               $urandom_range(int'(LAST_GREG_DAY)), $urandom_range(DAY_MAX)};
    for (int phase = 0; phase < 7; phase++) begin
      write_switch_day(starts[phase]);
      src_idle_pct  = (phase == 3) ? 0 : 30;
      sink_idle_pct = (phase == 3) ? 0 : 30;
      for (int i = 0; i < 150; i++) offer_day(pick_day());
    end
    src_idle_pct  = 30;
    sink_idle_pct = 30;
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    hold_request = 300;
    for (int i = 0; i < 80; i++) offer_day(pick_day());
    src_idle_pct = 30;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_switch();
    test_switch_extremes();
    test_random_traffic();
    test_backpressure();
    drain_dates();
    repeat (2 * NUM_STAGES) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/jdc_pkg.sv
rtl/core/jdc_year_pipe.sv
rtl/core/jdc_date_pipe.sv
rtl/core/julian_day_to_calendar_date.sv
tb/sv/tb.sv
